// ----- sv/inb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inb_pkg
// Shared types and constants for the I/Q impulse noise blanker.
// ----------------------------------------------------------------------------
package inb_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_THRESHOLD    = 3'd0;
    localparam logic [2:0] REG_RAMP_WIDTH   = 3'd1;
    localparam logic [2:0] REG_RAMP_STEP    = 3'd2;
    localparam logic [2:0] REG_ATTACK_COEF  = 3'd3;
    localparam logic [2:0] REG_RELEASE_COEF = 3'd4;

    // Longest blanking ramp; the delay line holds half of it.
    localparam int MAX_RAMP_WIDTH = 64;

    localparam int ENV_BITS = 24;

    typedef struct packed {
        logic signed [15:0] sample_q;
        logic signed [15:0] sample_i;
    } t_in_word;

    typedef struct packed {
        logic               pulse_detected;
        logic signed [15:0] out_q;
        logic signed [15:0] out_i;
    } t_out_word;

    typedef struct packed {
        logic [2:0]  index;
        logic [15:0] data;
    } t_cfg_word;

endpackage

// ----- sv/inb_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inb_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module inb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/inb_isqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inb_isqrt
// Digit-serial integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module inb_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [32:0] i_radicand,
    output logic        o_done,
    output logic [16:0] o_root
);

    logic [32:0] r_rem;
    logic [33:0] r_val;
    logic [16:0] r_root;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [34:0] n_trial;
    logic [34:0] n_rem2;

    // Bring down two radicand bits and try the next root bit.
    always_comb begin
        n_rem2  = {r_rem[32:0], r_val[33:32]};
        n_trial = n_rem2 - {16'd0, r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
                r_rem  <= '0;
                r_root <= '0;
                r_val  <= {1'b0, i_radicand};
            end else if (r_busy) begin
                r_val <= {r_val[31:0], 2'b00};
                if (!n_trial[34]) begin
                    r_rem  <= n_trial[32:0];
                    r_root <= {r_root[15:0], 1'b1};
                end else begin
                    r_rem  <= n_rem2[32:0];
                    r_root <= {r_root[15:0], 1'b0};
                end
                if (r_cnt == 5'd16) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 5'd1;
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ----- sv/iq_impulse_noise_blanker_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iq_impulse_noise_blanker_core
// Envelope-tracking impulse noise blanker for complex baseband samples.
// ----------------------------------------------------------------------------
// Usage:
//   One input word carries an I/Q sample; one output word returns the sample
//   delayed by ramp_width/2-1 words, scaled by the blanking gain, with a
//   flag when the input word just taken tripped the blanker.
//   Configuration words are taken only while the block is idle, and an input
//   word waits while a configuration word is offered. Writing ramp_width
//   empties the delay line with a clearing pass that writes zero to every entry.
//   After an input word is accepted, the square root is started, steps through
//   its 17 result bits and hands back the root; then the envelope, trip test,
//   gain, multiply and output rounding follow as registered steps.
//   One word is worked at a time, up to its write into the output register.
//   The output register parts the two sides: while a stalled receiver holds
//   it, the next word is taken and worked, then waits in the last stage.
//   After reset the delay line is cleared before the first input or
//   configuration word is accepted.
// ----------------------------------------------------------------------------
module iq_impulse_noise_blanker_core
    import inb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_word  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_data,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  t_cfg_word i_cfg_data
);

    localparam int DEPTH = MAX_RAMP_WIDTH / 2;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WW    = $clog2(MAX_RAMP_WIDTH + 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SQRT, S_ENV, S_ENV2, S_GAIN, S_GAIN2, S_MUL, S_OUT
    } t_state;

    t_state r_state;
    logic [15:0] r_threshold, r_step, r_attack, r_release;
    logic [6:0]  r_width;
    logic [ENV_BITS-1:0] r_env;
    logic [5:0]  r_cnt;
    logic [AW-1:0] r_wp, r_rp, r_clr;
    logic signed [15:0] r_si, r_sq;
    logic [16:0] r_mag;
    logic signed [41:0] r_prod;
    logic [16:0] r_gain;
    logic        r_trip;
    logic signed [33:0] r_yi, r_yq;
    logic        r_ovalid;
    t_out_word   r_odata;
    logic        r_sqrt_go;

    logic        w_sqrt_done;
    logic [16:0] w_root;
    logic [31:0] w_rd;
    logic [WW-1:0] w_w;
    logic [WW-1:0] w_h;
    logic        w_we;
    logic [AW-1:0] w_waddr;
    logic [31:0] w_wdata;
    logic [ENV_BITS:0] w_mag8;
    logic signed [25:0] w_d;
    logic signed [25:0] w_envn;
    logic [7:0]  w_m;
    logic signed [23:0] w_mstep;
    logic [32:0] w_rad;
    logic [15:0] w_coef;

    // Effective ramp width and half width.
    always_comb begin
        if (r_width < 7'd2) w_w = WW'(2);
        else if ({1'b0, r_width} > 8'(MAX_RAMP_WIDTH)) w_w = WW'(MAX_RAMP_WIDTH);
        else w_w = WW'(r_width);
        w_h = w_w >> 1;
    end

    assign w_rad = 33'(33'(r_si) * 33'(r_si) + 33'(r_sq) * 33'(r_sq));

    inb_isqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_sqrt_go),
        .i_radicand (w_rad),
        .o_done     (w_sqrt_done),
        .o_root     (w_root)
    );

    // Delay line memory holds I and Q side by side.
    assign w_we    = (r_state == S_CLEAR) || (o_ready && i_valid);
    assign w_waddr = (r_state == S_CLEAR) ? r_clr : r_wp;
    assign w_wdata = (r_state == S_CLEAR) ? 32'd0 : {i_data.sample_i, i_data.sample_q};

    inb_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_delay (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_rp),
        .o_rdata (w_rd)
    );

    // Envelope update arithmetic.
    assign w_mag8 = {r_mag, 8'd0};
    assign w_d    = $signed({2'b00, r_env}) - $signed({1'b0, w_mag8});
    assign w_envn = $signed({1'b0, w_mag8}) + 26'(r_prod >>> 16);
    assign w_coef = (w_mag8 > {1'b0, r_env}) ? r_attack : r_release;

    // Distance from the ramp ends.
    always_comb begin
        logic [7:0] a, b;
        a = 8'(r_cnt) + 8'd1;
        b = 8'(2 * w_h) - 8'd1 - 8'(r_cnt);
        w_m = ($signed(b) < $signed(a)) ? b : a;
    end
    assign w_mstep = 24'($signed(w_m)) * 24'($signed({1'b0, r_step}));

    assign o_ready     = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_valid     = r_ovalid;
    assign o_data      = r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_threshold <= 16'd66;
            r_width     <= 7'd30;
            r_step      <= 16'd3277;
            r_attack    <= 16'd9621;
            r_release   <= 16'd9621;
            r_env       <= '0;
            r_cnt       <= '0;
            r_wp        <= AW'(14 % DEPTH);
            r_rp        <= '0;
            r_clr       <= '0;
            r_ovalid    <= 1'b0;
            r_sqrt_go   <= 1'b0;
        end else begin
            r_sqrt_go <= 1'b0;
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(DEPTH - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_cfg_valid) begin
                        case (i_cfg_data.index)
                            REG_THRESHOLD:    r_threshold <= i_cfg_data.data;
                            REG_RAMP_STEP:    r_step      <= i_cfg_data.data;
                            REG_ATTACK_COEF:  r_attack    <= i_cfg_data.data;
                            REG_RELEASE_COEF: r_release   <= i_cfg_data.data;
                            REG_RAMP_WIDTH: begin
                                r_width <= i_cfg_data.data[6:0];
                                r_cnt   <= '0;
                                r_rp    <= '0;
                                r_clr   <= '0;
                                r_state <= S_CLEAR;
                                if (i_cfg_data.data[6:0] < 7'd4) r_wp <= '0;
                                else if (i_cfg_data.data[6:0] >= 7'(MAX_RAMP_WIDTH))
                                    r_wp <= AW'(DEPTH - 1);
                                else r_wp <= AW'(i_cfg_data.data[6:1] - 6'd1);
                            end
                            default: ;
                        endcase
                    end else if (o_ready && i_valid) begin
                        r_si      <= i_data.sample_i;
                        r_sq      <= i_data.sample_q;
                        r_sqrt_go <= 1'b1;
                        r_wp      <= (7'(r_wp) + 7'd1 >= 7'(w_h)) ? '0 : r_wp + AW'(1);
                        r_state   <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (w_sqrt_done) begin
                        r_mag   <= w_root;
                        r_state <= S_ENV;
                    end
                end
                S_ENV: begin
                    r_prod  <= 42'($signed({1'b0, w_coef})) * 42'(w_d);
                    r_state <= S_ENV2;
                end
                S_ENV2: begin
                    r_env  <= 24'(w_envn);
                    r_trip <= $signed({1'b0, w_mag8}) >
                              $signed(w_envn) + $signed({2'b00, r_threshold, 8'd0});
                    if ($signed({1'b0, w_mag8}) >
                        $signed(w_envn) + $signed({2'b00, r_threshold, 8'd0}))
                        r_cnt <= 6'(w_w - WW'(1));
                    r_state <= S_GAIN;
                end
                S_GAIN: begin
                    if (r_cnt == 6'd0) r_gain <= 17'd32768;
                    else if ($signed(w_mstep) >= 24'sd32768) r_gain <= '0;
                    else r_gain <= 17'(24'sd32768 - w_mstep);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_yi    <= 34'($signed(w_rd[31:16])) * 34'($signed({1'b0, r_gain}));
                    r_yq    <= 34'($signed(w_rd[15:0])) * 34'($signed({1'b0, r_gain}));
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // Wait here while the previous word is still held.
                    if (!r_ovalid || i_ready) begin
                        r_odata.out_i <= ((r_yi >>> 15) > 34'sd32767) ? 16'sh7fff :
                                         ((r_yi >>> 15) < -34'sd32768) ? 16'sh8000 :
                                         16'(r_yi >>> 15);
                        r_odata.out_q <= ((r_yq >>> 15) > 34'sd32767) ? 16'sh7fff :
                                         ((r_yq >>> 15) < -34'sd32768) ? 16'sh8000 :
                                         16'(r_yq >>> 15);
                        r_odata.pulse_detected <= r_trip;
                        r_ovalid <= 1'b1;
                        if (r_cnt != 6'd0) r_cnt <= r_cnt - 6'd1;
                        r_rp    <= (7'(r_rp) + 7'd1 >= 7'(w_h)) ? '0 : r_rp + AW'(1);
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
